### rtl/core/sral_pkg.sv
package sral_pkg;
    typedef enum logic [1:0] {
        CMD_SET    = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic start;
        logic step;
        logic finish;
    } t_ctl;

    typedef struct packed {
        logic last;
    } t_sts;
endpackage

### rtl/core/sral_if.sv
interface sral_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [63:0] range_start;
    logic [63:0] range_end;
    logic [31:0] new_color;
    logic [63:0] lookup_address;
    modport source(output valid, command, range_start, range_end, new_color, lookup_address,
                   input ready);
    modport sink(input valid, command, range_start, range_end, new_color, lookup_address,
                 output ready);
endinterface

interface sral_out_if #(parameter int CW = 5);
    logic          valid;
    logic          ready;
    logic          hit;
    logic [31:0]   found_color;
    logic          table_full;
    logic [CW-1:0] entry_count;
    modport source(output valid, hit, found_color, table_full, entry_count, input ready);
    modport sink(input valid, hit, found_color, table_full, entry_count, output ready);
endinterface

### rtl/core/sral_ctrl.sv
module sral_ctrl
    import sral_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.last) begin
                    o_ctl.finish = 1'b1;
                    n_state      = S_OUT;
                end else begin
                    o_ctl.step = 1'b1;
                end
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = r_state == S_IDLE;
    assign o_valid = r_state == S_OUT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

### rtl/core/sral_dp.sv
module sral_dp
    import sral_pkg::*;
#(
    parameter int N  = 16,
    parameter int AW = 4,
    parameter int CW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ctl          i_ctl,
    output t_sts          o_sts,
    input  logic [1:0]    i_command,
    input  logic [63:0]   i_range_start,
    input  logic [63:0]   i_range_end,
    input  logic [31:0]   i_new_color,
    input  logic [63:0]   i_lookup_address,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_data,
    output logic          o_hit,
    output logic [31:0]   o_found_color,
    output logic          o_table_full,
    output logic [CW-1:0] o_entry_count
);
    logic [63:0] r_st  [N];
    logic [63:0] r_en  [N];
    logic [31:0] r_col [N];
    logic [CW-1:0] r_used, r_rd, r_wr;
    logic [31:0] r_nocol;
    t_cmd        r_cmd;
    logic [63:0] r_s, r_e, r_a, r_best;
    logic [31:0] r_c, r_bcol;
    logic        r_found, r_full;

    logic [AW-1:0] rd_idx, wr_idx;
    logic [63:0]   cur_s, cur_e, sz;
    logic          scanning, match, inside_rng;

    assign rd_idx     = r_rd[AW-1:0];
    assign wr_idx     = r_wr[AW-1:0];
    assign scanning   = r_rd < r_used;
    assign cur_s      = r_st[rd_idx];
    assign cur_e      = r_en[rd_idx];
    assign match      = cur_s == r_s && cur_e == r_e;
    assign inside_rng = r_a >= cur_s && r_a < cur_e;
    assign sz         = cur_e - cur_s;
    assign o_sts.last = !scanning || r_cmd != CMD_SET && r_cmd != CMD_LOOKUP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_nocol <= '1;
        end else begin
            if (i_cfg_we) r_nocol <= i_cfg_data;
            if (i_ctl.start) begin
                r_cmd   <= t_cmd'(i_command);
                r_s     <= i_range_start;
                r_e     <= i_range_end;
                r_c     <= i_new_color;
                r_a     <= i_lookup_address;
                r_rd    <= '0;
                r_wr    <= '0;
                r_found <= 1'b0;
                r_bcol  <= '0;
                r_full  <= 1'b0;
                o_hit         <= 1'b0;
                o_found_color <= '0;
                o_table_full  <= 1'b0;
            end else if (i_ctl.step && scanning) begin
                r_rd <= r_rd + 1'b1;
                if (r_cmd == CMD_SET) begin
                    if (!match) begin
                        r_st[wr_idx]  <= cur_s;
                        r_en[wr_idx]  <= cur_e;
                        r_col[wr_idx] <= r_col[rd_idx];
                        r_wr <= r_wr + 1'b1;
                    end
                end else if (inside_rng && (!r_found || sz < r_best)) begin
                    r_found <= 1'b1;
                    r_best  <= sz;
                    r_bcol  <= r_col[rd_idx];
                end
            end else if (i_ctl.finish) begin
                unique case (r_cmd)
                    CMD_SET: begin
                        if (r_c == r_nocol) begin
                            r_used <= r_wr;
                        end else if (r_wr >= CW'(N)) begin
                            r_used       <= r_wr;
                            o_table_full <= 1'b1;
                        end else begin
                            r_st[wr_idx]  <= r_s;
                            r_en[wr_idx]  <= r_e;
                            r_col[wr_idx] <= r_c;
                            r_used        <= r_wr + 1'b1;
                        end
                    end
                    CMD_CLEAR: r_used <= '0;
                    CMD_LOOKUP: begin
                        o_hit         <= r_found;
                        o_found_color <= r_bcol;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_entry_count = r_used;
endmodule

### rtl/core/smallest_range_attribute_lookup_top.sv
// channel | dir | payload
// i_in    | in  | command, range_start, range_end, new_color, lookup_address
// o_out   | out | hit, found_color, table_full, entry_count
// cfg     | in  | i_cfg_we, i_cfg_data (no_color_value)
// A set or lookup goes through accept, a scan with one table entry read per
// scan cycle over the used entries, a finish step and a result step; clear
// and the unused code skip the scan. One item at a time; a stalled result
// holds the block. Synchronous active-low reset empties the table; no
// clearing pass.
module smallest_range_attribute_lookup_top
    import sral_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sral_in_if.sink    i_in,
    sral_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic [31:0] i_cfg_data
);
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    t_ctl ctl;
    t_sts sts;

    sral_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in.valid), .o_ready(i_in.ready),
        .o_valid(o_out.valid), .i_ready(o_out.ready),
        .i_sts(sts), .o_ctl(ctl)
    );

    sral_dp #(.N(TABLE_ENTRIES), .AW(AW), .CW(CW)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .o_sts(sts),
        .i_command(i_in.command), .i_range_start(i_in.range_start),
        .i_range_end(i_in.range_end), .i_new_color(i_in.new_color),
        .i_lookup_address(i_in.lookup_address),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_hit(o_out.hit), .o_found_color(o_out.found_color),
        .o_table_full(o_out.table_full), .o_entry_count(o_out.entry_count)
    );
endmodule

### rtl/core/sral_chk.sv
module sral_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_hit,
    input logic [31:0] i_out_color,
    input logic i_out_full
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready) else $error("input taken while result pending");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready) else $error("ready after accept");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_hit |-> i_out_color == 32'd0) else $error("color on miss");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_full))
        else $error("result dropped");
endmodule

bind smallest_range_attribute_lookup_top sral_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid), .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_out_hit(o_out.hit), .i_out_color(o_out.found_color),
    .i_out_full(o_out.table_full)
);
